>>> src/spq_pkg.sv
// Shared types, codes and default sizes of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;
  localparam int PAY_W      = 32;
  localparam int PRIO_IN_W  = 16;
  localparam int PRIO_W     = 15;

  typedef enum logic [1:0] {
    FN_ENQ = 2'd0,
    FN_DEQ = 2'd1,
    FN_CLR = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NEG   = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

>>> src/spq_cell.sv
// One slot of the sorted chain: holds an entry, shifts right on insert, left on removal.
module spq_cell #(
  parameter int DATA_W = spq_pkg::DATA_W_DEF
) (
  input  logic                       clk,
  input  spq_pkg::spq_ctl_t          ctl,
  input  logic                       occ,
  input  logic [DATA_W-1:0]          new_pay,
  input  logic [spq_pkg::PRIO_W-1:0] new_prio,
  input  logic [DATA_W-1:0]          left_pay,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic                       left_ins,
  input  logic [DATA_W-1:0]          right_pay,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  output logic                       ins,
  output logic [DATA_W-1:0]          pay,
  output logic [spq_pkg::PRIO_W-1:0] prio
);
  import spq_pkg::*;

  logic [DATA_W-1:0] pay_r, pay_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  // free slot or larger priority: new word lands here or further left
  assign ins  = !occ || (prio_r > new_prio);
  assign pay  = pay_r;
  assign prio = prio_r;

  always_comb begin
    pay_nxt  = pay_r;
    prio_nxt = prio_r;
    priority if (ctl.enq) begin
      if (ins) begin
        if (left_ins) begin
          pay_nxt  = left_pay;
          prio_nxt = left_prio;
        end else begin
          pay_nxt  = new_pay;
          prio_nxt = new_prio;
        end
      end
    end else if (ctl.deq) begin
      pay_nxt  = right_pay;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    pay_r  <= pay_nxt;
    prio_r <= prio_nxt;
  end

endmodule

>>> src/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: control, count and a chain of entry cells.
// The result word appears in the cycle after start is accepted, strobed by out_valid.
// Throughput: one operation per cycle; busy stays low, every cell compares and shifts at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (synchronous, rst_n low): the queue is emptied and no result is pending.
// Slot contents are not cleared; only slots below the count are ever read.
module sorted_priority_queue_core #(
  parameter int DEPTH  = spq_pkg::DEPTH_DEF,
  parameter int DATA_W = spq_pkg::DATA_W_DEF,
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [spq_pkg::PAY_W-1:0]     in_payload,
  input  logic signed [spq_pkg::PRIO_IN_W-1:0] in_prio,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic                          out_removed_valid,
  output logic [spq_pkg::PAY_W-1:0]     out_removed_payload,
  output logic [spq_pkg::PRIO_W-1:0]    out_removed_prio,
  output logic                          out_head_valid,
  output logic [spq_pkg::PAY_W-1:0]     out_head_payload,
  output logic [spq_pkg::PRIO_W-1:0]    out_head_prio,
  output logic [CNT_W-1:0]              out_fill
);
  import spq_pkg::*;

  logic              accept;
  func_t             func;
  logic              neg, full, empty;
  logic              enq_ok, deq_ok, clr;
  spq_ctl_t          ctl;
  logic [DATA_W-1:0] new_pay;
  logic [PRIO_W-1:0] new_prio;
  logic [PAY_W-1:0]  head_pay32;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic              rem_valid_r;
  logic [PAY_W-1:0]  rem_pay_r;
  logic [PRIO_W-1:0] rem_prio_r;

  logic [DATA_W-1:0] pay_w  [DEPTH];
  logic [PRIO_W-1:0] prio_w [DEPTH];
  logic              ins_w  [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign func   = func_t'(in_func);
  assign neg    = in_prio[PRIO_IN_W-1];
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign new_prio = in_prio[PRIO_W-1:0];

  generate
    if (DATA_W <= PAY_W) begin : g_narrow
      assign new_pay    = in_payload[DATA_W-1:0];
      assign head_pay32 = PAY_W'(pay_w[0]);
    end else begin : g_wide
      assign new_pay    = DATA_W'(in_payload);
      assign head_pay32 = pay_w[0][PAY_W-1:0];
    end
  endgenerate

  always_comb begin
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    clr        = 1'b0;
    status_nxt = ST_OK;
    if (accept) begin
      unique case (func)
        FN_ENQ: begin
          priority if (neg) begin
            status_nxt = ST_NEG;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            enq_ok = 1'b1;
          end
        end
        FN_DEQ: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            deq_ok = 1'b1;
          end
        end
        FN_CLR: clr = 1'b1;
        FN_NOP: ;
        default: ;
      endcase
    end
  end

  assign ctl.enq = enq_ok;
  assign ctl.deq = deq_ok;

  always_comb begin
    count_nxt = count_r;
    priority if (clr) begin
      count_nxt = '0;
    end else if (enq_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (deq_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int L = (i == 0) ? 0 : i - 1;
      localparam int R = (i == DEPTH - 1) ? i : i + 1;
      spq_cell #(
        .DATA_W (DATA_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occ        (CNT_W'(i) < count_r),
        .new_pay    (new_pay),
        .new_prio   (new_prio),
        .left_pay   (pay_w[L]),
        .left_prio  (prio_w[L]),
        .left_ins   ((i == 0) ? 1'b0 : ins_w[L]),
        .right_pay  (pay_w[R]),
        .right_prio (prio_w[R]),
        .ins        (ins_w[i]),
        .pay        (pay_w[i]),
        .prio       (prio_w[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // capture the outgoing head before the chain shifts
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      rem_valid_r <= deq_ok;
      rem_pay_r   <= deq_ok ? head_pay32 : '0;
      rem_prio_r  <= deq_ok ? prio_w[0] : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_removed_valid   = rem_valid_r;
  assign out_removed_payload = rem_pay_r;
  assign out_removed_prio    = rem_prio_r;
  assign out_head_valid      = !empty;
  assign out_head_payload    = empty ? '0 : head_pay32;
  assign out_head_prio       = empty ? '0 : prio_w[0];
  assign out_fill            = count_r;

endmodule
